### hdl/qlc_pkg.sv
`timescale 1ns / 1ps

package qlc_pkg;

    // Lexer mode codes. Codes six and seven never arise and decode as outside.
    localparam logic [2:0] MODE_OUT     = 3'd0;
    localparam logic [2:0] MODE_OUT_ESC = 3'd1;
    localparam logic [2:0] MODE_SQ      = 3'd2;
    localparam logic [2:0] MODE_SQ_ESC  = 3'd3;
    localparam logic [2:0] MODE_DQ      = 3'd4;
    localparam logic [2:0] MODE_DQ_ESC  = 3'd5;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef logic [2:0] t_mode;

    // Decision for one byte: whether it is kept and the mode it leaves.
    typedef struct packed {
        logic  keep;
        t_mode next_mode;
    } t_lex;

    // One result as it sits in the output or skid register.
    typedef struct packed {
        logic [7:0]  data;
        logic        keep;
        logic        last;
        logic [15:0] kept_length;
    } t_result;

endpackage

### hdl/qlc_lexer.sv
`timescale 1ns / 1ps

module qlc_lexer
    import qlc_pkg::*;
(
    input  t_mode      i_mode,
    input  logic [7:0] i_byte,
    output t_lex       o_lex
);

    always_comb begin
        o_lex.keep      = 1'b0;
        o_lex.next_mode = i_mode;
        case (i_mode)
            MODE_SQ: begin
                if (i_byte == CH_SQUOTE) begin
                    o_lex.keep      = 1'b1;
                    o_lex.next_mode = MODE_OUT;
                end else if (i_byte == CH_BSLASH) begin
                    o_lex.next_mode = MODE_SQ_ESC;
                end
            end
            MODE_SQ_ESC: begin
                o_lex.next_mode = MODE_SQ;
            end
            MODE_DQ: begin
                if (i_byte == CH_DQUOTE) begin
                    o_lex.keep      = 1'b1;
                    o_lex.next_mode = MODE_OUT;
                end else if (i_byte == CH_BSLASH) begin
                    o_lex.next_mode = MODE_DQ_ESC;
                end
            end
            MODE_DQ_ESC: begin
                o_lex.next_mode = MODE_DQ;
            end
            MODE_OUT_ESC: begin
                // An escaped quote outside a literal is plain text.
                o_lex.keep      = 1'b1;
                o_lex.next_mode = MODE_OUT;
            end
            default: begin
                o_lex.keep = 1'b1;
                if (i_byte == CH_DQUOTE) begin
                    o_lex.next_mode = MODE_DQ;
                end else if (i_byte == CH_SQUOTE) begin
                    o_lex.next_mode = MODE_SQ;
                end else if (i_byte == CH_BSLASH) begin
                    o_lex.next_mode = MODE_OUT_ESC;
                end else begin
                    o_lex.next_mode = MODE_OUT;
                end
            end
        endcase
    end

endmodule

### hdl/quoted_literal_collapser_top.sv
`timescale 1ns / 1ps

// Quoted literal collapser: takes a text one byte per transfer, last byte
// marked, and flags every byte inside single- or double-quoted literals as
// dropped while keeping the quote characters and everything outside. One
// result comes out for every byte, echoing it with its keep flag and the
// running count of kept bytes (saturating at 2**LENGTH_BITS - 1, shown in 16
// bits). Lexer mode and count return to outside and zero after the last byte.
// The block takes one byte every cycle while o_stall is low; each result is
// registered. The lexer mode and counter registers close the only loop, one
// byte a cycle. A skid register behind the output register lets input keep
// flowing while a result waits, and o_stall comes straight from a flop.
module quoted_literal_collapser_top
    import qlc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte,
    output logic        o_keep,
    output logic        o_last,
    output logic [15:0] o_kept_length
);

    localparam int EXT_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    t_mode                  r_mode;
    logic [LENGTH_BITS-1:0] r_count;
    logic [LENGTH_BITS-1:0] n_count;
    logic [EXT_BITS-1:0]    w_count_ext;
    t_lex                   w_lex;
    t_result                w_result;
    t_result                r_out;
    t_result                r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic                   w_in_xfer;
    logic                   w_out_xfer;

    qlc_lexer u_lexer (
        .i_mode (r_mode),
        .i_byte (i_byte),
        .o_lex  (w_lex)
    );

    assign w_in_xfer  = i_valid && !r_skid_valid;
    assign w_out_xfer = r_out_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (w_lex.keep && (r_count != {LENGTH_BITS{1'b1}})) begin
            n_count = r_count + 1'b1;
        end
    end

    assign w_count_ext          = EXT_BITS'(n_count);
    assign w_result.data        = i_byte;
    assign w_result.keep        = w_lex.keep;
    assign w_result.last        = i_last;
    assign w_result.kept_length = w_count_ext[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OUT;
            r_count <= '0;
        end else if (w_in_xfer) begin
            if (i_last) begin
                r_mode  <= MODE_OUT;
                r_count <= '0;
            end else begin
                r_mode  <= w_lex.next_mode;
                r_count <= n_count;
            end
        end
    end

    // The skid register only fills while the output register is held, and
    // input is refused until it drains into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_out_xfer) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_in_xfer;
                end
            end else if (w_in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_xfer) begin
                r_out <= w_result;
            end
        end else if (w_in_xfer) begin
            r_skid <= w_result;
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_byte        = r_out.data;
    assign o_keep        = r_out.keep;
    assign o_last        = r_out.last;
    assign o_kept_length = r_out.kept_length;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_DQ_ESC)
        else $error("lexer mode left the six defined codes");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last) |=> ((r_mode == MODE_OUT) && (r_count == '0)))
        else $error("lexer state not cleared after the last byte");

    a_drop_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !i_last && !w_lex.keep) |=> $stable(r_count))
        else $error("kept count moved on a dropped byte");

endmodule

### tb/quoted_literal_collapser_top_tb.sv
`timescale 1ns / 1ps

module quoted_literal_collapser_top_tb;
    import qlc_pkg::*;

    localparam int     LENGTH_BITS   = 16;
    localparam int     RESET_CYCLES  = 10;
    localparam int     RANDOM_ITEMS  = 1200;
    localparam int     QUIET_TAIL    = 200;
    localparam int     HOLD_AT       = 300;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     DRAIN_CYCLES  = 10;
    localparam int     MAX_SHOWN     = 10;
    localparam longint CYCLE_LIMIT   = 200_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_byte        = 8'h00;
    logic        i_last        = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_byte;
    logic        o_keep;
    logic        o_last;
    logic [15:0] o_kept_length;

    t_byte_item pending[$];
    t_result    expected_results[$];
    t_byte_item staged;

    // Predictor state: lexer mode and running count of kept bytes.
    t_mode                  lex_mode   = MODE_OUT;
    logic [LENGTH_BITS-1:0] kept_total = '0;

    int     gap_left     = 0;
    int     stall_left   = 0;
    int     hold_left    = 0;
    bit     hold_done    = 1'b0;
    int     results_seen = 0;
    int     errors       = 0;
    longint cycles       = 0;

    quoted_literal_collapser_top #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte       (i_byte),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte       (o_byte),
        .o_keep       (o_keep),
        .o_last       (o_last),
        .o_kept_length(o_kept_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_result predict_result(input logic [7:0] b, input logic last);
        t_result r;
        logic    keep;
        t_mode   nxt_mode;
        keep     = 1'b0;
        nxt_mode = lex_mode;
        case (lex_mode)
            MODE_SQ: begin
                if (b == CH_SQUOTE) begin
                    keep     = 1'b1;
                    nxt_mode = MODE_OUT;
                end else if (b == CH_BSLASH) begin
                    nxt_mode = MODE_SQ_ESC;
                end
            end
            MODE_SQ_ESC: nxt_mode = MODE_SQ;
            MODE_DQ: begin
                if (b == CH_DQUOTE) begin
                    keep     = 1'b1;
                    nxt_mode = MODE_OUT;
                end else if (b == CH_BSLASH) begin
                    nxt_mode = MODE_DQ_ESC;
                end
            end
            MODE_DQ_ESC: nxt_mode = MODE_DQ;
            MODE_OUT_ESC: begin
                keep     = 1'b1;
                nxt_mode = MODE_OUT;
            end
            default: begin
                keep = 1'b1;
                if (b == CH_DQUOTE) nxt_mode = MODE_DQ;
                else if (b == CH_SQUOTE) nxt_mode = MODE_SQ;
                else if (b == CH_BSLASH) nxt_mode = MODE_OUT_ESC;
                else nxt_mode = MODE_OUT;
            end
        endcase
        if (keep && kept_total != '1) kept_total = kept_total + 1'b1;
        r.data        = b;
        r.keep        = keep;
        r.last        = last;
        r.kept_length = kept_total[15:0];
        if (last) begin
            lex_mode   = MODE_OUT;
            kept_total = '0;
        end else begin
            lex_mode = nxt_mode;
        end
        return r;
    endfunction

    task automatic push_text(input string s);
        t_byte_item it;
        for (int k = 0; k < s.len(); k++) begin
            it.data = s[k];
            it.last = (k == s.len() - 1);
            pending.push_back(it);
        end
    endtask

    // Lexical texts lean on quotes and backslashes; the others are raw bytes.
    task automatic push_random_text(input int len, input bit lexical);
        t_byte_item it;
        int         pick;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (!lexical || pick >= 36) it.data = 8'($urandom_range(0, 255));
            else if (pick < 12) it.data = CH_DQUOTE;
            else if (pick < 24) it.data = CH_SQUOTE;
            else it.data = CH_BSLASH;
            it.last = (k == len - 1);
            pending.push_back(it);
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) expected_results.push_back(predict_result(i_byte, i_last));
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending.size() != 0) begin
                staged = pending.pop_front();
                i_valid <= 1'b1;
                i_byte  <= staged.data;
                i_last  <= staged.last;
                if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 17);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The long hold lets the sender keep offering until the block fills and stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (pending.size() <= QUIET_TAIL) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.data        = o_byte;
            got.keep        = o_keep;
            got.last        = o_last;
            got.kept_length = o_kept_length;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result: byte %02h keep %0d last %0d len %0d",
                                     got.data, got.keep, got.last, got.kept_length));
            end else begin
                want = expected_results.pop_front();
                if (got.data !== want.data || got.keep !== want.keep ||
                    got.last !== want.last || got.kept_length !== want.kept_length)
                    flag_error($sformatf({"mismatch: expected byte %02h keep %0d last %0d ",
                                          "len %0d, got byte %02h keep %0d last %0d len %0d"},
                                         want.data, want.keep, want.last, want.kept_length,
                                         got.data, got.keep, got.last, got.kept_length));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("quoted_literal_collapser_top_tb: errors");
            $finish;
        end
    end

    initial begin
        int  random_items;
        int  len;

        // Directed texts: single byte, byte extremes, both literal kinds, escapes
        // outside and inside, the other quote kind inside, and a literal left open.
        push_text("x");
        pending.push_back(t_byte_item'{data: 8'h00, last: 1'b0});
        pending.push_back(t_byte_item'{data: 8'hFF, last: 1'b1});
        push_text("\"ab\"c");
        push_text("'a\\'b'");
        push_text("\\\"q");
        push_text("\"'\"'\"'");
        push_text("\"x\\");
        push_text("y");

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            len = $urandom_range(1, 40);
            push_random_text(len, $urandom_range(0, 9) < 8);
            random_items += len;
        end

        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("quoted_literal_collapser_top_tb: clean");
        else
            $display("quoted_literal_collapser_top_tb: errors");
        $finish;
    end

endmodule
